/* rtl/core/smr_pkg.sv */
// Shared types and constants for the spherical mirror reflection block.
// No dependencies.
package smr_pkg;

    localparam int POS_W = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2
    } t_cfg_idx;

    localparam logic [POS_W-1:0] CENTER_X_RST = 32'd0;
    localparam logic [POS_W-1:0] CENTER_Y_RST = 32'd0;
    localparam logic [POS_W-1:0] CENTER_Z_RST = 32'd376176640;

    // Control that travels with every item down the pipe.
    typedef struct packed {
        logic valid;
        logic degen;
    } t_tag;

endpackage

/* rtl/core/smr_front.sv */
// Front end: normal vector, common normalizing shift, dot products and numerators.
// Depends on smr_pkg.
module smr_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [FRAC_BITS+2:0] i_d [3],
    input  logic signed [smr_pkg::POS_W-1:0] i_h [3],
    input  logic signed [smr_pkg::POS_W-1:0] i_c [3],
    output smr_pkg::t_tag               o_tag,
    input  logic                        i_ready,
    output logic signed [FRAC_BITS+2:0] o_d [3],
    output logic [2*((60-FRAC_BITS-3)/2)+1:0] o_den,
    output logic [(FRAC_BITS+3)+2*((60-FRAC_BITS-3)/2)+5:0] o_rem [3],
    output logic [2:0]                  o_neg
);
    import smr_pkg::*;

    localparam int DIR_W = FRAC_BITS + 3;
    localparam int VB    = (60 - DIR_W) / 2;
    localparam int VW    = VB + 1;
    localparam int MAG_W = POS_W + 1;
    localparam int SMAX  = MAG_W - VB;
    localparam int S_W   = $clog2(SMAX + 1);
    localparam int P_W   = DIR_W + VW;
    localparam int SQ_W  = 2 * VW;
    localparam int DOT_W = P_W + 2;
    localparam int DEN_W = 2 * VB + 2;
    localparam int NUM_W = DOT_W + VW + 1;
    localparam int R_W   = NUM_W + 1;
    localparam int NST   = 6;

    t_tag r_tag [NST];
    logic adv [NST];

    logic signed [MAG_W-1:0] r1_v [3];
    logic signed [DIR_W-1:0] r1_d [3];
    logic signed [VW-1:0]    r2_vs [3];
    logic signed [DIR_W-1:0] r2_d [3];
    logic signed [P_W-1:0]   r3_pd [3];
    logic signed [SQ_W-1:0]  r3_sq [3];
    logic signed [VW-1:0]    r3_vs [3];
    logic signed [DIR_W-1:0] r3_d [3];
    logic signed [DOT_W-1:0] r4_dv;
    logic [DEN_W-1:0]        r4_den;
    logic signed [VW-1:0]    r4_vs [3];
    logic signed [DIR_W-1:0] r4_d [3];
    logic signed [NUM_W-1:0] r5_num [3];
    logic [DEN_W-1:0]        r5_den;
    logic signed [DIR_W-1:0] r5_d [3];

    logic [MAG_W-1:0]        w_mag [3];
    logic [MAG_W-1:0]        w_or;
    logic [S_W-1:0]          w_s;
    logic                    w_zero;
    logic signed [VW-1:0]    n_vs [3];
    logic [NUM_W-1:0]        w_nmag [3];

    // Ready chain: a stage moves when it is empty or its successor moves.
    always_comb begin
        adv[NST-1] = !r_tag[NST-1].valid || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_tag[k].valid || adv[k+1];
        end
    end
    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            if (adv[0]) begin
                r_tag[0] <= '{valid: i_valid, degen: 1'b0};
            end
            if (adv[1]) begin
                r_tag[1] <= '{valid: r_tag[0].valid, degen: w_zero};
            end
            for (int k = 2; k < NST; k++) begin
                if (adv[k]) begin
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    end

    // Shift search: the OR of the magnitudes has the same top bit as the largest.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r1_v[i][MAG_W-1] ? MAG_W'(-r1_v[i]) : MAG_W'(r1_v[i]);
        end
        w_or   = w_mag[0] | w_mag[1] | w_mag[2];
        w_zero = (w_or == '0);
        w_s    = '0;
        for (int k = 1; k <= SMAX; k++) begin
            if ((w_or >> (VB + k - 1)) != '0) begin
                w_s = S_W'(k);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_vs[i] = r1_v[i][MAG_W-1] ? -VW'(w_mag[i] >> w_s) : VW'(w_mag[i] >> w_s);
            w_nmag[i] = r5_num[i][NUM_W-1] ? NUM_W'(-r5_num[i]) : NUM_W'(r5_num[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i] <= MAG_W'(i_c[i]) - MAG_W'(i_h[i]);
                r1_d[i] <= i_d[i];
            end
        end
        if (adv[1]) begin
            r2_vs <= n_vs;
            r2_d  <= r1_d;
        end
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_pd[i] <= P_W'(r2_d[i]) * P_W'(r2_vs[i]);
                r3_sq[i] <= SQ_W'(r2_vs[i]) * SQ_W'(r2_vs[i]);
            end
            r3_vs <= r2_vs;
            r3_d  <= r2_d;
        end
        if (adv[3]) begin
            r4_dv  <= DOT_W'(r3_pd[0]) + DOT_W'(r3_pd[1]) + DOT_W'(r3_pd[2]);
            r4_den <= DEN_W'($unsigned(r3_sq[0])) + DEN_W'($unsigned(r3_sq[1]))
                    + DEN_W'($unsigned(r3_sq[2]));
            r4_vs  <= r3_vs;
            r4_d   <= r3_d;
        end
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                r5_num[i] <= (NUM_W'(r4_dv) * NUM_W'(r4_vs[i])) <<< 1;
            end
            r5_den <= r4_den;
            r5_d   <= r4_d;
        end
        if (adv[5]) begin
            for (int i = 0; i < 3; i++) begin
                // add half the divisor up front: rounds to nearest, ties away
                o_rem[i] <= R_W'(w_nmag[i]) + R_W'(r5_den >> 1);
                o_neg[i] <= r5_num[i][NUM_W-1];
            end
            o_den <= r5_den;
            o_d   <= r5_d;
        end
    end

    assign o_tag = r_tag[NST-1];

endmodule

/* rtl/core/smr_div_cell.sv */
// One restoring-division cell: settles one quotient bit in each of three lanes.
// Depends on smr_pkg.
module smr_div_cell #(
    parameter int FRAC_BITS = 16,
    parameter int BIT       = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smr_pkg::t_tag               i_tag,
    output logic                        o_ready,
    input  logic signed [FRAC_BITS+2:0] i_d [3],
    input  logic [2*((60-FRAC_BITS-3)/2)+1:0] i_den,
    input  logic [(FRAC_BITS+3)+2*((60-FRAC_BITS-3)/2)+5:0] i_rem [3],
    input  logic [FRAC_BITS+4:0]        i_q [3],
    input  logic [2:0]                  i_neg,
    output smr_pkg::t_tag               o_tag,
    input  logic                        i_ready,
    output logic signed [FRAC_BITS+2:0] o_d [3],
    output logic [2*((60-FRAC_BITS-3)/2)+1:0] o_den,
    output logic [(FRAC_BITS+3)+2*((60-FRAC_BITS-3)/2)+5:0] o_rem [3],
    output logic [FRAC_BITS+4:0]        o_q [3],
    output logic [2:0]                  o_neg
);
    import smr_pkg::*;

    localparam int DIR_W = FRAC_BITS + 3;
    localparam int VB    = (60 - DIR_W) / 2;
    localparam int R_W   = DIR_W + 2 * VB + 6;
    localparam int Q_W   = DIR_W + 2;

    logic [R_W-1:0] w_sub;
    logic           adv;

    assign w_sub   = R_W'(i_den) << BIT;
    assign adv     = !o_tag.valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else if (adv) begin
            o_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                if (i_rem[i] >= w_sub) begin
                    o_rem[i] <= i_rem[i] - w_sub;
                    o_q[i]   <= i_q[i] | (Q_W'(1) << BIT);
                end else begin
                    o_rem[i] <= i_rem[i];
                    o_q[i]   <= i_q[i];
                end
            end
            o_d   <= i_d;
            o_den <= i_den;
            o_neg <= i_neg;
        end
    end

endmodule

/* rtl/core/smr_back.sv */
// Output stage: apply sign, subtract from the incident direction, saturate; degenerate items pass the direction.
// Depends on smr_pkg.
module smr_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smr_pkg::t_tag               i_tag,
    output logic                        o_ready,
    input  logic signed [FRAC_BITS+2:0] i_d [3],
    input  logic [FRAC_BITS+4:0]        i_q [3],
    input  logic [2:0]                  i_neg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [FRAC_BITS+2:0] o_refl [3],
    output logic                        o_degenerate
);
    import smr_pkg::*;

    localparam int DIR_W = FRAC_BITS + 3;
    localparam int Q_W   = DIR_W + 2;
    localparam int X_W   = Q_W + 2;
    localparam logic signed [X_W-1:0] HI = X_W'((64'sd1 <<< (DIR_W - 1)) - 1);
    localparam logic signed [X_W-1:0] LO = -HI - X_W'(1);

    logic                    adv;
    logic signed [X_W-1:0]   w_qs [3];
    logic signed [X_W-1:0]   w_r [3];
    logic signed [DIR_W-1:0] n_refl [3];

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qs[i] = i_neg[i] ? -X_W'($signed({1'b0, i_q[i]}))
                               : X_W'($signed({1'b0, i_q[i]}));
            w_r[i]  = X_W'(i_d[i]) - w_qs[i];
            if (i_tag.degen) begin
                n_refl[i] = i_d[i];
            end else if (w_r[i] > HI) begin
                n_refl[i] = DIR_W'(HI);
            end else if (w_r[i] < LO) begin
                n_refl[i] = DIR_W'(LO);
            end else begin
                n_refl[i] = DIR_W'(w_r[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_refl       <= n_refl;
            o_degenerate <= i_tag.degen;
        end
    end

endmodule

/* rtl/core/spherical_mirror_reflection_top.sv */
// Pipeline: 6 front stages, FRAC_BITS+5 division cells, 1 output stage.
// Throughput: one item per cycle while i_ready holds; every stage is a register with its own valid bit.
// Reset: synchronous active-low i_rst_n empties the pipe and loads the sphere
// centre registers with their defaults (0, 0, 5740.0).
// Depends on smr_pkg, smr_front, smr_div_cell, smr_back.
module spherical_mirror_reflection_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [smr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [smr_pkg::POS_W-1:0]        i_cfg_data,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [FRAC_BITS+2:0]      i_dir_x,
    input  logic signed [FRAC_BITS+2:0]      i_dir_y,
    input  logic signed [FRAC_BITS+2:0]      i_dir_z,
    input  logic signed [smr_pkg::POS_W-1:0] i_hit_x,
    input  logic signed [smr_pkg::POS_W-1:0] i_hit_y,
    input  logic signed [smr_pkg::POS_W-1:0] i_hit_z,
    // output channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [FRAC_BITS+2:0]      o_refl_x,
    output logic signed [FRAC_BITS+2:0]      o_refl_y,
    output logic signed [FRAC_BITS+2:0]      o_refl_z,
    output logic                             o_degenerate
);
    import smr_pkg::*;

    localparam int DIR_W = FRAC_BITS + 3;
    localparam int VB    = (60 - DIR_W) / 2;
    localparam int DEN_W = 2 * VB + 2;
    localparam int R_W   = DIR_W + 2 * VB + 6;
    localparam int Q_W   = DIR_W + 2;

    logic signed [POS_W-1:0] r_center [3];

    // Hold the centre; writes beyond the last register drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= CENTER_X_RST;
            r_center[1] <= CENTER_Y_RST;
            r_center[2] <= CENTER_Z_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [DIR_W-1:0] w_dir [3];
    logic signed [POS_W-1:0] w_hit [3];

    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;
    assign w_hit[0] = i_hit_x;
    assign w_hit[1] = i_hit_y;
    assign w_hit[2] = i_hit_z;

    // Links of the division chain: index 0 comes from the front end,
    // index Q_W feeds the output stage.
    t_tag                    c_tag [Q_W+1];
    logic                    c_rdy [Q_W+1];
    logic signed [DIR_W-1:0] c_d   [Q_W+1][3];
    logic [DEN_W-1:0]        c_den [Q_W+1];
    logic [R_W-1:0]          c_rem [Q_W+1][3];
    logic [Q_W-1:0]          c_q   [Q_W+1][3];
    logic [2:0]              c_neg [Q_W+1];

    assign c_q[0][0] = '0;
    assign c_q[0][1] = '0;
    assign c_q[0][2] = '0;

    smr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_d     (w_dir),
        .i_h     (w_hit),
        .i_c     (r_center),
        .o_tag   (c_tag[0]),
        .i_ready (c_rdy[0]),
        .o_d     (c_d[0]),
        .o_den   (c_den[0]),
        .o_rem   (c_rem[0]),
        .o_neg   (c_neg[0])
    );

    // Each cell settles one quotient bit, most significant first.
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        smr_div_cell #(.FRAC_BITS(FRAC_BITS), .BIT(Q_W - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (c_tag[k]),
            .o_ready (c_rdy[k]),
            .i_d     (c_d[k]),
            .i_den   (c_den[k]),
            .i_rem   (c_rem[k]),
            .i_q     (c_q[k]),
            .i_neg   (c_neg[k]),
            .o_tag   (c_tag[k+1]),
            .i_ready (c_rdy[k+1]),
            .o_d     (c_d[k+1]),
            .o_den   (c_den[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_q     (c_q[k+1]),
            .o_neg   (c_neg[k+1])
        );
    end

    logic signed [DIR_W-1:0] w_refl [3];

    smr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (c_tag[Q_W]),
        .o_ready      (c_rdy[Q_W]),
        .i_d          (c_d[Q_W]),
        .i_q          (c_q[Q_W]),
        .i_neg        (c_neg[Q_W]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_refl       (w_refl),
        .o_degenerate (o_degenerate)
    );

    assign o_refl_x = w_refl[0];
    assign o_refl_y = w_refl[1];
    assign o_refl_z = w_refl[2];

endmodule

/* rtl/core/smr_checker.sv */
// Port-level checks for the reflection block, and the bind that attaches them.
// Depends on spherical_mirror_reflection_top.
module smr_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic signed [FRAC_BITS+2:0] o_refl_x,
    input logic signed [FRAC_BITS+2:0] o_refl_y,
    input logic signed [FRAC_BITS+2:0] o_refl_z,
    input logic                        o_degenerate
);

    // An empty output stage lets the whole pipe advance.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage empty");

    // Downstream ready propagates back to the input.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output drains");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_refl_x) && $stable(o_refl_y)
            && $stable(o_refl_z) && $stable(o_degenerate))
        else $error("stalled result changed");

endmodule

bind spherical_mirror_reflection_top smr_checker #(.FRAC_BITS(FRAC_BITS)) u_smr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_refl_x     (o_refl_x),
    .o_refl_y     (o_refl_y),
    .o_refl_z     (o_refl_z),
    .o_degenerate (o_degenerate)
);
